### design/vrms_pkg.sv
// shared types, register codes, sat32 and move_index helpers for the vertex transform
package vrms_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 32;
    localparam int QShift        = 16;

    // register indexes on the configuration port
    localparam logic [CfgIndexWidth-1:0] REG_OPERATION = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_AXIS      = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_AMOUNT    = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_COS       = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_SIN       = 3'd4;

    // operation codes
    localparam logic [1:0] OP_ROTATE = 2'd0;
    localparam logic [1:0] OP_MOVE   = 2'd1;
    localparam logic [1:0] OP_SCALE  = 2'd2;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic signed [17:0] COS_RESET = 18'sd65536;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic               end_of_batch;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               out_last;
    } result_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [1:0]         axis;
        logic signed [31:0] amount;
        logic signed [17:0] cos_value;
        logic signed [17:0] sin_value;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] index;
    } commit_t;

    typedef logic signed [31:0] offset_array_t [3];

    // clamp a wide signed value to the 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if ((&v[63:31]) || !(|v[63:31])) begin
            r = v[31:0];
        end else if (v[63]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

    // move uses z for the unused axis code
    function automatic logic [1:0] move_index(input logic [1:0] axis);
        logic [1:0] r;
        case (axis)
            AXIS_X:  r = AXIS_X;
            AXIS_Y:  r = AXIS_Y;
            default: r = AXIS_Z;
        endcase
        return r;
    endfunction

endpackage

### design/vertex_rotate_move_scale.sv
// top level: input register, transform datapath, result register
//
//  channel | ports                          | transfer when
//  --------+--------------------------------+--------------------
//  vertex  | s_valid, s_ready, s_data       | s_valid && s_ready
//  result  | m_valid, m_ready, m_data       | m_valid && m_ready
//  config  | cfg_we, cfg_index, cfg_wdata   | cfg_we
//
// one vertex per cycle unless m_ready stalls; m_valid follows the result register
// the multipliers of the rotate/scale path sit between the input and result registers
// both stages hold while the result register is full and m_ready is low
// reset clears both valid flags and the three offsets and loads the config defaults
module vertex_rotate_move_scale (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  vrms_pkg::vertex_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output vrms_pkg::result_t                  m_data,
    input  logic                               cfg_we,
    input  logic [vrms_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [vrms_pkg::CfgDataWidth-1:0]  cfg_wdata
);
    import vrms_pkg::*;

    vertex_t       in_reg;
    logic          in_valid_reg;
    result_t       out_reg;
    logic          out_valid_reg;
    result_t       res;
    cfg_t          cfg;
    offset_array_t prev_offset;
    commit_t       commit;
    logic          out_free;
    logic          advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // commit takes effect as the vertex leaves the input stage
    assign commit.valid = advance && (cfg.operation == OP_MOVE) && in_reg.end_of_batch;
    assign commit.index = move_index(cfg.axis);

    vrms_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .commit      (commit),
        .cfg         (cfg),
        .prev_offset (prev_offset)
    );

    vrms_xform u_xform (
        .vtx         (in_reg),
        .cfg         (cfg),
        .prev_offset (prev_offset),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### design/vrms_regs.sv
// configuration registers and committed per-axis move offsets
module vrms_regs (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [vrms_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [vrms_pkg::CfgDataWidth-1:0]     cfg_wdata,
    input  vrms_pkg::commit_t                     commit,
    output vrms_pkg::cfg_t                        cfg,
    output vrms_pkg::offset_array_t               prev_offset
);
    import vrms_pkg::*;

    cfg_t          cfg_reg;
    offset_array_t prev_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.operation <= OP_ROTATE;
            cfg_reg.axis      <= AXIS_X;
            cfg_reg.amount    <= '0;
            cfg_reg.cos_value <= COS_RESET;
            cfg_reg.sin_value <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_OPERATION: cfg_reg.operation <= cfg_wdata[1:0];
                REG_AXIS:      cfg_reg.axis      <= cfg_wdata[1:0];
                REG_AMOUNT:    cfg_reg.amount    <= cfg_wdata;
                REG_COS:       cfg_reg.cos_value <= cfg_wdata[17:0];
                REG_SIN:       cfg_reg.sin_value <= cfg_wdata[17:0];
                default: ;
            endcase
        end
    end

    // last vertex of a batch under move stores the current amount
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_offset_reg[0] <= '0;
            prev_offset_reg[1] <= '0;
            prev_offset_reg[2] <= '0;
        end else if (commit.valid) begin
            prev_offset_reg[commit.index] <= cfg_reg.amount;
        end
    end

    assign cfg         = cfg_reg;
    assign prev_offset = prev_offset_reg;

endmodule

### design/vrms_xform.sv
// transform datapath: rotate, move or scale one vertex, or pass it through
module vrms_xform (
    input  vrms_pkg::vertex_t       vtx,
    input  vrms_pkg::cfg_t          cfg,
    input  vrms_pkg::offset_array_t prev_offset,
    output vrms_pkg::result_t       res
);
    import vrms_pkg::*;

    logic signed [31:0] rot_a;
    logic signed [31:0] rot_b;
    logic signed [49:0] prod_ca;
    logic signed [49:0] prod_sb;
    logic signed [49:0] prod_sa;
    logic signed [49:0] prod_cb;
    logic signed [50:0] rot_sum1;
    logic signed [50:0] rot_sum2;
    logic signed [31:0] rot_out1;
    logic signed [31:0] rot_out2;
    logic signed [63:0] scl_x;
    logic signed [63:0] scl_y;
    logic signed [63:0] scl_z;
    logic [1:0]         mv_idx;
    logic signed [31:0] mv_coord;
    logic signed [33:0] mv_sum;
    logic signed [31:0] mv_out;

    // rotation pair (a, b): out1 = c*a - s*b, out2 = s*a + c*b
    always_comb begin
        case (cfg.axis)
            AXIS_X: begin
                rot_a = vtx.in_y;
                rot_b = vtx.in_z;
            end
            AXIS_Y: begin
                rot_a = vtx.in_z;
                rot_b = vtx.in_x;
            end
            default: begin
                rot_a = vtx.in_x;
                rot_b = vtx.in_y;
            end
        endcase
    end

    assign prod_ca  = 50'(cfg.cos_value) * 50'(rot_a);
    assign prod_sb  = 50'(cfg.sin_value) * 50'(rot_b);
    assign prod_sa  = 50'(cfg.sin_value) * 50'(rot_a);
    assign prod_cb  = 50'(cfg.cos_value) * 50'(rot_b);
    assign rot_sum1 = 51'(prod_ca) - 51'(prod_sb);
    assign rot_sum2 = 51'(prod_sa) + 51'(prod_cb);
    assign rot_out1 = sat32(64'(rot_sum1 >>> QShift));
    assign rot_out2 = sat32(64'(rot_sum2 >>> QShift));

    assign scl_x = 64'(vtx.in_x) * 64'(cfg.amount);
    assign scl_y = 64'(vtx.in_y) * 64'(cfg.amount);
    assign scl_z = 64'(vtx.in_z) * 64'(cfg.amount);

    assign mv_idx = move_index(cfg.axis);

    always_comb begin
        case (mv_idx)
            AXIS_X:  mv_coord = vtx.in_x;
            AXIS_Y:  mv_coord = vtx.in_y;
            default: mv_coord = vtx.in_z;
        endcase
    end

    assign mv_sum = 34'(mv_coord) + 34'(cfg.amount) - 34'(prev_offset[mv_idx]);
    assign mv_out = sat32(64'(mv_sum));

    always_comb begin
        res.out_x    = vtx.in_x;
        res.out_y    = vtx.in_y;
        res.out_z    = vtx.in_z;
        res.out_last = vtx.end_of_batch;
        case (cfg.operation)
            OP_ROTATE: begin
                case (cfg.axis)
                    AXIS_X: begin
                        res.out_y = rot_out1;
                        res.out_z = rot_out2;
                    end
                    AXIS_Y: begin
                        res.out_z = rot_out1;
                        res.out_x = rot_out2;
                    end
                    AXIS_Z: begin
                        res.out_x = rot_out1;
                        res.out_y = rot_out2;
                    end
                    default: ;
                endcase
            end
            OP_MOVE: begin
                case (mv_idx)
                    AXIS_X:  res.out_x = mv_out;
                    AXIS_Y:  res.out_y = mv_out;
                    default: res.out_z = mv_out;
                endcase
            end
            OP_SCALE: begin
                // zero factor leaves the vertex as it is
                if (cfg.amount != '0) begin
                    res.out_x = sat32(scl_x >>> QShift);
                    res.out_y = sat32(scl_y >>> QShift);
                    res.out_z = sat32(scl_z >>> QShift);
                end
            end
            default: ;
        endcase
    end

endmodule

### tb/sv/vertex_rotate_move_scale_test.sv
// self-checking testbench for the vertex rotate / move / scale block
module vertex_rotate_move_scale_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vrms_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] AXIS_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam longint I32_TOP    = 64'sd2147483647;
    localparam longint I32_BOTTOM = -64'sd2147483647 - 64'sd1;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    vertex_t                  s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    result_t                  m_data;
    logic                     cfg_we    = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_wdata = '0;

    // shadow of the register file and of the committed move offsets
    cfg_t shadow_cfg = '{operation: OP_ROTATE, axis: AXIS_X, amount: '0,
                         cos_value: COS_RESET, sin_value: '0};
    logic signed [31:0] committed [3] = '{default: '0};

    result_t pending_results [$];

    bit no_idle       = 1'b0;
    int stall_request = 0;
    int errors        = 0;
    int checked_count = 0;
    int sent_count    = 0;
    int rotate_items  = 0;
    int move_items    = 0;
    int scale_items   = 0;
    int passthru_items = 0;
    int commit_count  = 0;
    int long_stalls   = 0;

    vertex_rotate_move_scale u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [31:0] clamp_to_i32(input longint v);
        logic signed [31:0] r;
        if (v > I32_TOP) begin
            r = 32'sh7fff_ffff;
        end else if (v < I32_BOTTOM) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // expected output of one vertex; also advances the committed offsets
    function automatic result_t transform_vertex(input vertex_t v);
        result_t    r;
        longint     x, y, z, c, s, a, delta;
        logic [1:0] lane;
        x = longint'(v.in_x);
        y = longint'(v.in_y);
        z = longint'(v.in_z);
        c = longint'(shadow_cfg.cos_value);
        s = longint'(shadow_cfg.sin_value);
        a = longint'(shadow_cfg.amount);
        r.out_x    = v.in_x;
        r.out_y    = v.in_y;
        r.out_z    = v.in_z;
        r.out_last = v.end_of_batch;
        case (shadow_cfg.operation)
            OP_ROTATE: begin
                rotate_items++;
                case (shadow_cfg.axis)
                    AXIS_X: begin
                        r.out_y = clamp_to_i32((c * y - s * z) >>> QShift);
                        r.out_z = clamp_to_i32((s * y + c * z) >>> QShift);
                    end
                    AXIS_Y: begin
                        r.out_x = clamp_to_i32((c * x + s * z) >>> QShift);
                        r.out_z = clamp_to_i32((c * z - s * x) >>> QShift);
                    end
                    AXIS_Z: begin
                        r.out_x = clamp_to_i32((c * x - s * y) >>> QShift);
                        r.out_y = clamp_to_i32((s * x + c * y) >>> QShift);
                    end
                    default: ;
                endcase
            end
            OP_MOVE: begin
                move_items++;
                // the unused axis code moves z
                lane  = (shadow_cfg.axis == AXIS_NONE) ? AXIS_Z : shadow_cfg.axis;
                delta = a - longint'(committed[lane]);
                case (lane)
                    AXIS_X:  r.out_x = clamp_to_i32(x + delta);
                    AXIS_Y:  r.out_y = clamp_to_i32(y + delta);
                    default: r.out_z = clamp_to_i32(z + delta);
                endcase
                if (v.end_of_batch) begin
                    committed[lane] = shadow_cfg.amount;
                    commit_count++;
                end
            end
            OP_SCALE: begin
                scale_items++;
                if (a != 0) begin
                    r.out_x = clamp_to_i32((x * a) >>> QShift);
                    r.out_y = clamp_to_i32((y * a) >>> QShift);
                    r.out_z = clamp_to_i32((z * a) >>> QShift);
                end
            end
            default: passthru_items++;
        endcase
        return r;
    endfunction

    function automatic vertex_t vtx(input logic signed [31:0] x, input logic signed [31:0] y,
                                    input logic signed [31:0] z, input logic last);
        vertex_t v;
        v.in_x = x;
        v.in_y = y;
        v.in_z = z;
        v.end_of_batch = last;
        return v;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] r;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       r = 32'sh8000_0000;
                    1:       r = 32'sh7fff_ffff;
                    2:       r = 32'sd0;
                    default: r = -32'sd1;
                endcase
            end
            1, 2, 3, 4: r = $urandom;
            default:    r = int'($urandom_range(0, 1 << 22)) - (1 << 21);
        endcase
        return r;
    endfunction

    function automatic logic signed [17:0] rand_trig();
        logic signed [17:0] r;
        int t;
        case ($urandom_range(0, 5))
            0: r = 18'($urandom);
            1: begin
                case ($urandom_range(0, 2))
                    0:       r = 18'sd65536;
                    1:       r = -18'sd65536;
                    default: r = 18'sd0;
                endcase
            end
            default: begin
                t = int'($urandom_range(0, 131072)) - 65536;
                r = t[17:0];
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] rand_amount(input logic [1:0] op);
        logic signed [31:0] r;
        if (op == OP_SCALE) begin
            case ($urandom_range(0, 5))
                0:       r = 32'sd0;
                1:       r = $urandom;
                default: r = int'($urandom_range(0, 1 << 18)) - (1 << 17);
            endcase
        end else begin
            case ($urandom_range(0, 3))
                0:       r = $urandom;
                default: r = int'($urandom_range(0, 1 << 25)) - (1 << 24);
            endcase
        end
        return r;
    endfunction

    task automatic send_vertex(input vertex_t v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(transform_vertex(v));
        sent_count++;
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] reg_index,
                             input logic [CfgDataWidth-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_wdata <= data;
        case (reg_index)
            REG_OPERATION: shadow_cfg.operation = data[1:0];
            REG_AXIS:      shadow_cfg.axis      = data[1:0];
            REG_AMOUNT:    shadow_cfg.amount    = data;
            REG_COS:       shadow_cfg.cos_value = data[17:0];
            REG_SIN:       shadow_cfg.sin_value = data[17:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_mode(input logic [1:0] op, input logic [1:0] ax,
                            input logic signed [31:0] amt,
                            input logic signed [17:0] c, input logic signed [17:0] s);
        wait_idle();
        write_reg(REG_OPERATION, {30'd0, op});
        write_reg(REG_AXIS, {30'd0, ax});
        write_reg(REG_AMOUNT, amt);
        write_reg(REG_COS, {{14{c[17]}}, c});
        write_reg(REG_SIN, {{14{s[17]}}, s});
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // reset values give an identity rotation about x
    task automatic test_reset_state();
        send_vertex(vtx(32'sh0001_8000, 32'shfffd_c000, 32'sh0003_0000, 1'b0));
        send_vertex(vtx(32'sh7fff_ffff, 32'sh8000_0000, -32'sd1, 1'b1));
    endtask

    task automatic test_rotate_cases();
        set_mode(OP_ROTATE, AXIS_X, 32'sd0, 18'sd0, 18'sd65536);
        send_vertex(vtx(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b0));
        // odd factors on negative values exercise floor rounding
        set_mode(OP_ROTATE, AXIS_X, 32'sd0, 18'sd46341, 18'sd46341);
        send_vertex(vtx(32'sd0, -32'sd3, 32'sd1, 1'b1));
        set_mode(OP_ROTATE, AXIS_Y, 32'sd0, -18'sd65536, 18'sd65536);
        send_vertex(vtx(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0));
        set_mode(OP_ROTATE, AXIS_Z, 32'sd0, 18'sh1ffff, 18'sh20000);
        send_vertex(vtx(32'sh8000_0000, 32'sh8000_0000, 32'sd5, 1'b0));
        send_vertex(vtx(32'sh7fff_ffff, -32'sd1, 32'sd0, 1'b1));
        set_mode(OP_ROTATE, AXIS_NONE, 32'sd0, 18'sd12345, -18'sd777);
        send_vertex(vtx(32'sd7, 32'sd8, 32'sd9, 1'b0));
    endtask

    task automatic test_move_cases();
        set_mode(OP_MOVE, AXIS_X, 32'sh0005_0000, COS_RESET, 18'sd0);
        send_vertex(vtx(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b0));
        send_vertex(vtx(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b1));
        send_vertex(vtx(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b0));
        set_mode(OP_MOVE, AXIS_X, -32'sh0003_0000, COS_RESET, 18'sd0);
        send_vertex(vtx(32'sh000a_0000, 32'sd0, 32'sd0, 1'b1));
        // unused axis code moves z, then the full-range delta saturates both ways
        set_mode(OP_MOVE, AXIS_NONE, 32'sh8000_0000, COS_RESET, 18'sd0);
        send_vertex(vtx(32'sd0, 32'sd0, 32'sh8000_0000, 1'b1));
        set_mode(OP_MOVE, AXIS_Z, 32'sh7fff_ffff, COS_RESET, 18'sd0);
        send_vertex(vtx(32'sd0, 32'sd0, 32'sh7fff_ffff, 1'b0));
        send_vertex(vtx(32'sd0, 32'sd0, 32'sh8000_0000, 1'b0));
        set_mode(OP_MOVE, AXIS_Y, 32'sh0001_2345, COS_RESET, 18'sd0);
        send_vertex(vtx(32'sd0, -32'sd5, 32'sd0, 1'b1));
    endtask

    task automatic test_scale_cases();
        set_mode(OP_SCALE, AXIS_X, 32'sd0, COS_RESET, 18'sd0);
        send_vertex(vtx(32'sh7fff_ffff, 32'sh8000_0000, 32'sd123, 1'b1));
        set_mode(OP_SCALE, AXIS_Y, 32'sh8000_0000, COS_RESET, 18'sd0);
        send_vertex(vtx(32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 1'b0));
        set_mode(OP_SCALE, AXIS_Z, 32'sh7fff_ffff, COS_RESET, 18'sd0);
        send_vertex(vtx(32'sd3, -32'sd3, 32'sh0001_0000, 1'b0));
        set_mode(OP_SCALE, AXIS_X, 32'sh0000_8000, COS_RESET, 18'sd0);
        send_vertex(vtx(-32'sd1, 32'sd1, -32'sd65537, 1'b1));
    endtask

    // the unused operation passes the vertex and must not commit
    task automatic test_unused_operation();
        set_mode(OP_UNUSED, AXIS_X, 32'sh0005_0000, COS_RESET, 18'sd0);
        send_vertex(vtx(32'sd1, 32'sd2, 32'sd3, 1'b1));
        set_mode(OP_MOVE, AXIS_X, 32'sh0005_0000, COS_RESET, 18'sd0);
        send_vertex(vtx(32'sd0, 32'sd0, 32'sd0, 1'b0));
    endtask

    task automatic test_random_phases(input int items);
        int         done;
        int         n;
        int         batch_left;
        logic [1:0] op;
        logic       last;
        done = 0;
        batch_left = 0;
        while (done < items) begin
            case ($urandom_range(0, 7))
                0, 1:    op = OP_ROTATE;
                2, 3, 4: op = OP_MOVE;
                5, 6:    op = OP_SCALE;
                default: op = OP_UNUSED;
            endcase
            set_mode(op, 2'($urandom_range(0, 3)), rand_amount(op), rand_trig(), rand_trig());
            n = $urandom_range(8, 30);
            for (int i = 0; i < n; i++) begin
                // mostly well-formed batches, now and then a flipped batch flag
                if (batch_left == 0) batch_left = $urandom_range(1, 6);
                batch_left--;
                last = (batch_left == 0);
                if ($urandom_range(0, 9) == 0) last = ~last;
                send_vertex(vtx(rand_coord(), rand_coord(), rand_coord(), last));
            end
            done += n;
        end
    endtask

    task automatic test_burst();
        set_mode(OP_ROTATE, 2'($urandom_range(0, 2)), 32'sd0, rand_trig(), rand_trig());
        no_idle = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_vertex(vtx(rand_coord(), rand_coord(), rand_coord(), 1'($urandom)));
        end
        wait_idle();
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        set_mode(OP_MOVE, 2'($urandom_range(0, 3)), rand_amount(OP_MOVE), COS_RESET, 18'sd0);
        stall_request = LONG_HOLD;
        no_idle = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_vertex(vtx(rand_coord(), rand_coord(), rand_coord(), 1'(i % 5 == 4)));
        end
        no_idle = 1'b0;
        // sender holds until the block has fully drained
        wait_results();
        for (int i = 0; i < 20; i++) begin
            send_vertex(vtx(rand_coord(), rand_coord(), rand_coord(), 1'(i % 4 == 3)));
        end
    endtask

    // result receiver with random and requested long hold-offs
    initial begin
        int hold;
        wait (aresetn === 1'b1);
        forever begin
            if (stall_request > 0) begin
                hold = stall_request;
                stall_request = 0;
                long_stalls++;
            end else begin
                hold = no_idle ? 0 : $urandom_range(0, 17);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name,
                     $signed(want), $signed(got));
            errors++;
        end
    endtask

    // checks every result transfer against the oldest expectation
    initial begin
        result_t want;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, m_data);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("out_x", want.out_x, m_data.out_x);
                    compare_field("out_y", want.out_y, m_data.out_y);
                    compare_field("out_z", want.out_z, m_data.out_z);
                    compare_field("out_last", {31'd0, want.out_last}, {31'd0, m_data.out_last});
                    checked_count++;
                end
            end
        end
    end

    // ends the run when no transfer happens for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (aresetn === 1'b1);
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: timeout, no transfer for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_rotate_cases();
        test_move_cases();
        test_scale_cases();
        test_unused_operation();
        test_random_phases(400);
        test_burst();
        test_backpressure();
        wait_idle();
        repeat (8) @(posedge aclk);
        $display("run covered %0d vertices (%0d rotate, %0d move, %0d scale, %0d unused op)",
                 sent_count, rotate_items, move_items, scale_items, passthru_items);
        $display("%0d results checked, %0d offset commits, %0d long result stalls, %0d errors",
                 checked_count, commit_count, long_stalls, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
design/vrms_pkg.sv
design/vrms_regs.sv
design/vrms_xform.sv
design/vertex_rotate_move_scale.sv
tb/sv/vertex_rotate_move_scale_test.sv
